// File: hw/rtl/bscu_pkg.sv
// ----------------------------------------------------------------------------
// bscu_pkg
// shared constants and types for the bucket-switch coefficient update block
// ----------------------------------------------------------------------------
package bscu_pkg;

  // switch counter store
  localparam int NUM_ELEMS  = 16384;
  localparam int ELEM_IDX_W = $clog2(NUM_ELEMS);

  // coefficient format, signed q4.12 by default
  localparam int COEFF_BITS = 16;

  // switch counters saturate at +/- CNT_LIMIT
  localparam int CNT_W     = 5;
  localparam int CNT_LIMIT = 15;
  localparam int BAR_W     = 4;

  typedef logic signed [CNT_W-1:0] cnt_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COEFF = 3'd4;

  // register reset values
  localparam int QUANT_THR_RST = 20;
  localparam int GRAD_THR_RST  = 2048;
  localparam int BAR_LEVEL_RST = 7;
  localparam int MIN_COEFF_RST = 64;

endpackage

// File: hw/rtl/bucket_switch_coeff_update.sv
// ----------------------------------------------------------------------------
// bucket_switch_coeff_update
// power-of-two quantizer with per-element bucket switch counters
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready: an element index, its coefficient, a
// scaled gradient step and a mask bit. Each item gives one result on
// out_valid/out_ready: the updated clamped coefficient, the power-of-two
// quantized input and a flag telling whether the element's counter switched.
// Registers are written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to this, as configuration writes are taken throughout.
// Throughput is one item per cycle while out_ready is high. The counters
// live in a single-port-write, single-port-read memory with a registered
// read; the read is issued at acceptance and the write-back happens when the
// item leaves stage 1, with the last write forwarded so back-to-back items
// on the same index see fresh counts. Each item passes stage 1, then the
// output register; when out_ready is low both hold, and in_ready drops once
// both are full. After reset the counter memory is cleared one entry per
// cycle, all NUM_ELEMS entries (16384 by default); in_ready stays low until
// it is done.
// ----------------------------------------------------------------------------
module bucket_switch_coeff_update #(
  parameter int COEFF_BITS = bscu_pkg::COEFF_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [bscu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEFF_BITS-2:0]            cfg_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bscu_pkg::ELEM_IDX_W-1:0]  elem_index,
  input  logic signed [COEFF_BITS-1:0]     coeff_in,
  input  logic signed [COEFF_BITS-1:0]     grad_step,
  input  logic                             mask_bit,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COEFF_BITS-1:0]     coeff_out,
  output logic signed [COEFF_BITS-1:0]     quantized,
  output logic                             switched
);

  localparam int MAG_W  = COEFF_BITS - 1;
  localparam int IDX_W  = bscu_pkg::ELEM_IDX_W;
  localparam int CNT_W  = bscu_pkg::CNT_W;
  localparam int BAR_W  = bscu_pkg::BAR_W;
  localparam int WIDE_W = COEFF_BITS + 2;

  localparam logic [COEFF_BITS-1:0] TOP_POW = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam logic signed [COEFF_BITS-1:0] POS_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam bscu_pkg::cnt_t CNT_MAX = CNT_W'(bscu_pkg::CNT_LIMIT);
  localparam bscu_pkg::cnt_t CNT_MIN = CNT_W'(-bscu_pkg::CNT_LIMIT);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] quant_thr;
  logic [MAG_W-1:0] grad_thr;
  logic [BAR_W-1:0] bar_level;
  logic [MAG_W-1:0] max_coeff;
  logic [MAG_W-1:0] min_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_thr <= MAG_W'(bscu_pkg::QUANT_THR_RST);
      grad_thr  <= MAG_W'(bscu_pkg::GRAD_THR_RST);
      bar_level <= BAR_W'(bscu_pkg::BAR_LEVEL_RST);
      max_coeff <= {MAG_W{1'b1}};
      min_coeff <= MAG_W'(bscu_pkg::MIN_COEFF_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        bscu_pkg::REG_QUANT_THR: quant_thr <= cfg_data;
        bscu_pkg::REG_GRAD_THR:  grad_thr  <= cfg_data;
        bscu_pkg::REG_BAR_LEVEL: bar_level <= cfg_data[BAR_W-1:0];
        bscu_pkg::REG_MAX_COEFF: max_coeff <= cfg_data;
        bscu_pkg::REG_MIN_COEFF: min_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake and clearing pass
  // --------------------------------------------------------------------------
  logic             clr_busy;
  logic [IDX_W-1:0] clr_addr;
  logic             s1_vld;
  logic             s1_fire;
  logic             in_fire;

  assign s1_fire  = s1_vld && (!out_valid || out_ready);
  assign in_ready = !clr_busy && (!s1_vld || s1_fire);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(bscu_pkg::NUM_ELEMS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: quantize and threshold the gradient straight off the input
  // --------------------------------------------------------------------------
  logic [COEFF_BITS-1:0]        c_mag;
  logic [COEFF_BITS-1:0]        c_smear;
  logic [COEFF_BITS-1:0]        c_msb;
  logic [COEFF_BITS-1:0]        c_pow;
  logic signed [COEFF_BITS-1:0] q_val;
  logic [COEFF_BITS-1:0]        g_mag;
  logic                         g_act;

  always_comb begin
    c_mag   = coeff_in[COEFF_BITS-1] ? COEFF_BITS'(-coeff_in) : COEFF_BITS'(coeff_in);
    // fill ones below the leading one, then keep only the leading one
    c_smear = c_mag;
    for (int k = 1; k < COEFF_BITS; k = k * 2) begin
      c_smear = c_smear | (c_smear >> k);
    end
    c_msb = c_smear ^ (c_smear >> 1);
    // bit below the leading one set means at or past the midpoint, ties go up
    c_pow = ((c_mag & (c_msb >> 1)) != '0) ? (c_msb << 1) : c_msb;
    if (c_mag == '0 || c_mag < {1'b0, quant_thr}) begin
      q_val = '0;
    end else if (coeff_in[COEFF_BITS-1]) begin
      q_val = -$signed(c_pow);
    end else if (c_pow == TOP_POW) begin
      q_val = POS_MAX;
    end else begin
      q_val = $signed(c_pow);
    end
    g_mag = grad_step[COEFF_BITS-1] ? COEFF_BITS'(-grad_step) : COEFF_BITS'(grad_step);
    g_act = g_mag > {1'b0, grad_thr};
  end

  logic [IDX_W-1:0]             s1_idx;
  logic signed [COEFF_BITS-1:0] s1_q;
  logic                         s1_gact;
  logic                         s1_gneg;
  logic                         s1_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_fire) begin
      s1_vld <= 1'b1;
    end else if (s1_fire) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx  <= elem_index;
      s1_q    <= q_val;
      s1_gact <= g_act;
      s1_gneg <= grad_step[COEFF_BITS-1];
      s1_mask <= mask_bit;
    end
  end

  // --------------------------------------------------------------------------
  // counter memory, read at acceptance, written back from stage 1
  // --------------------------------------------------------------------------
  bscu_pkg::cnt_t   cnt_mem [bscu_pkg::NUM_ELEMS];
  bscu_pkg::cnt_t   rd_cnt;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  bscu_pkg::cnt_t   mem_wdata;
  bscu_pkg::cnt_t   cnt_new;

  assign mem_we    = clr_busy || s1_fire;
  assign mem_waddr = clr_busy ? clr_addr : s1_idx;
  assign mem_wdata = clr_busy ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_cnt <= cnt_mem[elem_index];
    end
  end

  // last item write, for a read that raced it at the same edge
  logic             wr_vld;
  logic [IDX_W-1:0] wr_idx;
  bscu_pkg::cnt_t   wr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld <= 1'b0;
    end else if (s1_fire) begin
      wr_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wr_idx <= s1_idx;
      wr_cnt <= cnt_new;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: counter update, switch and clamp
  // --------------------------------------------------------------------------
  bscu_pkg::cnt_t           cnt_cur;
  logic signed [CNT_W:0]    cnt_sum;
  bscu_pkg::cnt_t           cnt_sat;
  logic [CNT_W-1:0]         cnt_mag;
  logic [BAR_W-1:0]         bar_eff;
  logic                     act;
  logic                     up;
  logic                     q_pos;
  logic [COEFF_BITS:0]      q_mag;
  logic [COEFF_BITS:0]      q_mag_sw;
  logic signed [WIDE_W-1:0] nc;
  logic signed [WIDE_W-1:0] lim;
  logic signed [WIDE_W-1:0] nc_clamp;

  always_comb begin
    cnt_cur = (wr_vld && wr_idx == s1_idx) ? wr_cnt : rd_cnt;
    cnt_sum = {cnt_cur[CNT_W-1], cnt_cur};
    if (s1_gact) begin
      cnt_sum = s1_gneg ? cnt_sum - (CNT_W+1)'(1) : cnt_sum + (CNT_W+1)'(1);
    end
    if (cnt_sum > (CNT_W+1)'(bscu_pkg::CNT_LIMIT)) begin
      cnt_sat = CNT_MAX;
    end else if (cnt_sum < -(CNT_W+1)'(bscu_pkg::CNT_LIMIT)) begin
      cnt_sat = CNT_MIN;
    end else begin
      cnt_sat = cnt_sum[CNT_W-1:0];
    end
    cnt_mag = cnt_sat[CNT_W-1] ? CNT_W'(-cnt_sat) : CNT_W'(cnt_sat);
    bar_eff = (bar_level == '0) ? BAR_W'(1) : bar_level;
    act     = cnt_mag >= {1'b0, bar_eff};
    up      = !cnt_sat[CNT_W-1];
    cnt_new = act ? '0 : cnt_sat;

    q_pos    = !s1_q[COEFF_BITS-1] && (s1_q != '0);
    // most negative value has a magnitude one past the signed range
    q_mag    = s1_q[COEFF_BITS-1] ? (COEFF_BITS+1)'($unsigned(-s1_q))
                                  : (COEFF_BITS+1)'($unsigned(s1_q));
    q_mag_sw = (up == q_pos) ? (q_mag << 1) : (q_mag >> 1);

    if (!act) begin
      nc = WIDE_W'(s1_q);
    end else if (s1_q == '0) begin
      if (!s1_mask) begin
        nc = '0;
      end else if (up) begin
        nc = $signed(WIDE_W'(min_coeff));
      end else begin
        nc = -$signed(WIDE_W'(min_coeff));
      end
    end else if (s1_q[COEFF_BITS-1]) begin
      nc = -$signed(WIDE_W'(q_mag_sw));
    end else begin
      nc = $signed(WIDE_W'(q_mag_sw));
    end

    lim = $signed(WIDE_W'(max_coeff));
    if (nc > lim) begin
      nc_clamp = lim;
    end else if (nc < -lim) begin
      nc_clamp = -lim;
    end else begin
      nc_clamp = nc;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      coeff_out <= nc_clamp[COEFF_BITS-1:0];
      quantized <= s1_q;
      switched  <= act;
    end
  end

`ifndef SYNTHESIS
  // no item may enter while the counter memory is being cleared
  assert property (@(posedge clk) disable iff (rst) clr_busy |-> !in_ready)
    else $error("item accepted during counter clearing pass");

  // stored counters stay inside the saturation range
  assert property (@(posedge clk) disable iff (rst)
    s1_vld |-> (cnt_cur >= CNT_MIN && cnt_cur <= CNT_MAX))
    else $error("switch counter out of range");

  // a switch clears the counter and shows up in the next result
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && act) |=> (out_valid && switched && wr_vld && wr_cnt == '0))
    else $error("switch not reflected in result or counter");
`endif

endmodule
